// ----- hdl/pbvr_pkg.sv -----
// Package with the types, constants and helper function of the video register block.
package pbvr_pkg;

    localparam int STORE_DEPTH  = 8192;
    localparam int ADDR_W       = 13;
    localparam int PIX_W        = 3;
    localparam int PIX_PER_WORD = 8;
    localparam int WORD_W       = PIX_W * PIX_PER_WORD;

    localparam logic [7:0] WEIGHT_0 = 8'h21;
    localparam logic [7:0] WEIGHT_1 = 8'h47;
    localparam logic [7:0] WEIGHT_2 = 8'h97;
    localparam logic [PIX_W-1:0] FULL_MASK = 3'h7;

    typedef enum logic [2:0] {
        K_PALETTE    = 3'd0,
        K_SCROLL_X   = 3'd1,
        K_SCROLL_Y   = 3'd2,
        K_BITMAP     = 3'd3,
        K_CONTROL    = 3'd4,
        K_PIXEL_READ = 3'd5
    } t_kind;

    typedef logic [PIX_PER_WORD-1:0][PIX_W-1:0] t_word;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data;
        logic              scroll_y_high;
        logic [7:0]        pixel_x;
        logic [7:0]        pixel_y;
        logic              flip;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       color_index;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             color_valid;
        logic [8:0]       scroll_x;
        logic [8:0]       scroll_y;
        logic [PIX_W-1:0] pixel;
        logic             pixel_opaque;
    } t_out_item;

    // Resistor ladder: the three weights sum to at most 0xFF.
    function automatic logic [7:0] weigh(input logic [2:0] bits);
        logic [7:0] sum;
        sum = (bits[0] ? WEIGHT_0 : 8'h00)
            + (bits[1] ? WEIGHT_1 : 8'h00)
            + (bits[2] ? WEIGHT_2 : 8'h00);
        return sum;
    endfunction

endpackage

// ----- hdl/pbvr_if.sv -----
// Valid/ready channel interfaces for the input and result transactions.
interface pbvr_in_if;
    import pbvr_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface pbvr_out_if;
    import pbvr_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ----- hdl/plane_bitmap_video_registers.sv -----
// Top level of the video register block: framebuffer, palette decode and scroll registers.
//
//  Channel  | Direction | Payload                                  | Handshake
//  ---------+-----------+------------------------------------------+------------
//  i_in     | in        | kind, address, data, scroll/pixel fields | valid/ready
//  o_out    | out       | palette, scroll and pixel read results   | valid/ready
//
// An accepted transaction passes through the second-stage register and the result register;
// one transaction per cycle is sustained when the result side keeps up.
// The framebuffer RAM is read when a transaction is accepted and written back when it
// leaves the second stage; a read after a bitmap write to the same word is forwarded.
// After reset a clearing pass zeroes the 8192 framebuffer words, during which
// no transaction is accepted.
// A stalled result holds the second stage, which in turn holds off new transactions.
module plane_bitmap_video_registers (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pbvr_in_if.sink           i_in,
    pbvr_out_if.source        o_out
);
    import pbvr_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_s1_valid;
    t_in_item          r_s1_item;
    logic [2:0]        r_s1_sel;
    logic              r_s1_fwd;
    t_word             r_fwd_word;

    logic              r_out_valid;
    t_out_item         r_out_item;
    t_out_item         n_out_item;

    logic [7:0]        r_ctrl;
    logic [7:0]        n_ctrl;
    logic [8:0]        r_hscroll;
    logic [8:0]        n_hscroll;
    logic [8:0]        r_vscroll;
    logic [8:0]        n_vscroll;

    logic              w_accept;
    logic              w_s1_adv;
    logic [7:0]        w_in_x;
    logic [7:0]        w_in_y;
    logic [ADDR_W-1:0] w_raddr;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic [WORD_W-1:0] w_rdata;
    t_word             w_old_word;
    t_word             w_new_word;
    logic [PIX_W-1:0]  w_mask_raw;
    logic [PIX_W-1:0]  w_mask;
    logic [7:0]        w_nd;
    logic              w_s1_bitmap;
    logic              w_fwd_hit;

    assign w_s1_adv    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == ST_RUN) && (!r_s1_valid || w_s1_adv);
    assign w_accept    = i_in.valid && i_in.ready;

    // Flipped coordinates are 255 minus the display position.
    assign w_in_x  = i_in.item.flip ? ~i_in.item.pixel_x : i_in.item.pixel_x;
    assign w_in_y  = i_in.item.flip ? ~i_in.item.pixel_y : i_in.item.pixel_y;
    assign w_raddr = (i_in.item.kind == K_PIXEL_READ) ? {w_in_x[7:3], w_in_y}
                                                      : i_in.item.address;

    assign w_s1_bitmap = r_s1_valid && (r_s1_item.kind == K_BITMAP);
    // The RAM returns the old word when the write lands in the same cycle as the read.
    assign w_fwd_hit   = w_s1_bitmap && (r_s1_item.address == w_raddr);

    assign w_old_word = r_s1_fwd ? r_fwd_word : t_word'(w_rdata);
    assign w_mask_raw = ~r_ctrl[3:1];
    assign w_mask     = (w_mask_raw == '0) ? FULL_MASK : w_mask_raw;

    always_comb begin
        for (int i = 0; i < PIX_PER_WORD; i++) begin
            w_new_word[i] = r_s1_item.data[i] ? (w_old_word[i] | w_mask)
                                              : (w_old_word[i] & ~w_mask);
        end
    end

    assign w_we    = (r_state == ST_CLEAR) || (w_s1_bitmap && w_s1_adv);
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_s1_item.address;
    assign w_wdata = (r_state == ST_CLEAR) ? '0 : WORD_W'(w_new_word);

    pbvr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_nd = ~r_s1_item.data;

    always_comb begin
        n_ctrl    = r_ctrl;
        n_hscroll = r_hscroll;
        n_vscroll = r_vscroll;
        n_out_item = '0;
        case (r_s1_item.kind)
            K_PALETTE: begin
                n_out_item.color_index = r_s1_item.address[7:0];
                n_out_item.red         = weigh(w_nd[2:0]);
                n_out_item.green       = weigh(w_nd[5:3]);
                n_out_item.blue        = weigh({w_nd[7:6], ~r_ctrl[7]});
                n_out_item.color_valid = 1'b1;
            end
            K_SCROLL_X: begin
                n_hscroll = {r_ctrl[0], r_s1_item.data};
            end
            K_SCROLL_Y: begin
                n_vscroll = {r_s1_item.scroll_y_high, r_s1_item.data};
            end
            K_CONTROL: begin
                n_ctrl = r_s1_item.data;
            end
            K_PIXEL_READ: begin
                n_out_item.pixel        = w_old_word[r_s1_sel];
                n_out_item.pixel_opaque = (w_old_word[r_s1_sel] != '0);
            end
            default: begin
            end
        endcase
        n_out_item.scroll_x = n_hscroll;
        n_out_item.scroll_y = n_vscroll;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_fwd    <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctrl      <= '0;
            r_hscroll   <= '0;
            r_vscroll   <= '0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    r_state <= ST_RUN;
                end
            end

            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_s1_item  <= i_in.item;
                r_s1_sel   <= w_in_x[2:0];
                r_s1_fwd   <= w_fwd_hit;
                r_fwd_word <= w_new_word;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (w_s1_adv) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_out_item <= n_out_item;
                    r_ctrl     <= n_ctrl;
                    r_hscroll  <= n_hscroll;
                    r_vscroll  <= n_vscroll;
                end
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_state == ST_RUN))
        else $error("transaction accepted during the clearing pass");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1_valid)
        else $error("accepted transaction did not reach the second stage");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("second stage changed while the result side stalled");

    a_fwd_after_bitmap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_s1_fwd) |-> $past(w_s1_bitmap && w_accept))
        else $error("forwarding set without a preceding bitmap write");

endmodule

// ----- hdl/pbvr_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module pbvr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- dv/tb_plane_bitmap_video_registers.sv -----
// Testbench for the video register block: directed and random bus accesses checked against a predictor.
`timescale 1ns / 100ps

module tb_plane_bitmap_video_registers;
    import pbvr_pkg::*;

    localparam t_kind K_UNUSED_LO = t_kind'(3'd6);
    localparam t_kind K_UNUSED_HI = t_kind'(3'd7);
    localparam int RANDOM_PER_PHASE = 250;
    localparam int NUM_PHASES       = 4;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD        = 300;
    localparam int DRAIN_CYCLES     = 8;

    typedef struct {
        t_in_item  access;
        bit        fixed;
        t_out_item fixed_result;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    pbvr_in_if  in_if ();
    pbvr_out_if out_if ();

    plane_bitmap_video_registers u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted copy of the block's state.
    t_word      fb_words [STORE_DEPTH];
    logic [7:0] ctrl_reg;
    logic [8:0] hscroll;
    logic [8:0] vscroll;

    t_out_item     expected_results [$];
    t_directed_row directed_rows [$];
    logic [12:0]   hot_words [16];

    int send_idle_pct;
    int recv_stall_pct;
    // The stimulus raises the request count; the result side starts one hold-off per request.
    int hold_request = 0;
    int hold_taken   = 0;
    int hold_left    = 0;
    int error_count  = 0;
    int cycle_count  = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] resistor_level(input logic [2:0] bits);
        return ({8{bits[0]}} & WEIGHT_0) + ({8{bits[1]}} & WEIGHT_1)
             + ({8{bits[2]}} & WEIGHT_2);
    endfunction

    // Applies one access to the predicted state and returns the result it produces.
    function automatic t_out_item predict_access(input t_in_item acc);
        t_out_item        res;
        logic [7:0]       inv;
        logic [PIX_W-1:0] mask;
        t_word            w;
        logic [7:0]       x;
        logic [7:0]       y;
        res = '0;
        inv = ~acc.data;
        case (acc.kind)
            K_PALETTE: begin
                res.color_index = acc.address[7:0];
                res.red         = resistor_level(inv[2:0]);
                res.green       = resistor_level(inv[5:3]);
                res.blue        = resistor_level({inv[7], inv[6], ~ctrl_reg[7]});
                res.color_valid = 1'b1;
            end
            K_SCROLL_X: begin
                hscroll = {ctrl_reg[0], acc.data};
            end
            K_SCROLL_Y: begin
                vscroll = {acc.scroll_y_high, acc.data};
            end
            K_BITMAP: begin
                mask = ~ctrl_reg[3:1];
                if (mask == '0) begin
                    mask = FULL_MASK;
                end
                w = fb_words[acc.address];
                for (int i = 0; i < PIX_PER_WORD; i++) begin
                    w[i] = acc.data[i] ? (w[i] | mask) : (w[i] & ~mask);
                end
                fb_words[acc.address] = w;
            end
            K_CONTROL: begin
                ctrl_reg = acc.data;
            end
            K_PIXEL_READ: begin
                x = acc.flip ? ~acc.pixel_x : acc.pixel_x;
                y = acc.flip ? ~acc.pixel_y : acc.pixel_y;
                w = fb_words[{x[7:3], y}];
                res.pixel        = w[x[2:0]];
                res.pixel_opaque = |res.pixel;
            end
            default: begin
            end
        endcase
        res.scroll_x = hscroll;
        res.scroll_y = vscroll;
        return res;
    endfunction

    function automatic t_in_item make_access(input t_kind k, input logic [12:0] a,
                                             input logic [7:0] d, input logic yhi,
                                             input logic [7:0] px, input logic [7:0] py,
                                             input logic fl);
        t_in_item acc;
        acc.kind          = k;
        acc.address       = a;
        acc.data          = d;
        acc.scroll_y_high = yhi;
        acc.pixel_x       = px;
        acc.pixel_y       = py;
        acc.flip          = fl;
        return acc;
    endfunction

    function automatic t_out_item make_result(input logic [7:0] cidx, input logic [7:0] r,
                                              input logic [7:0] g, input logic [7:0] b,
                                              input logic cv, input logic [8:0] sx,
                                              input logic [8:0] sy, input logic [2:0] pix,
                                              input logic op);
        t_out_item res;
        res.color_index  = cidx;
        res.red          = r;
        res.green        = g;
        res.blue         = b;
        res.color_valid  = cv;
        res.scroll_x     = sx;
        res.scroll_y     = sy;
        res.pixel        = pix;
        res.pixel_opaque = op;
        return res;
    endfunction

    task automatic add_row(input t_in_item acc);
        t_directed_row row;
        row.access       = acc;
        row.fixed        = 1'b0;
        row.fixed_result = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_fixed_row(input t_in_item acc, input t_out_item res);
        t_directed_row row;
        row.access       = acc;
        row.fixed        = 1'b1;
        row.fixed_result = res;
        directed_rows.push_back(row);
    endtask

    task automatic build_directed_rows();
        // Reads of a freshly cleared framebuffer, both orientations and both corners, then scroll writes.
        add_fixed_row(make_access(K_PIXEL_READ, 13'h0000, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0),
                      make_result(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 9'h000, 9'h000, 3'd0, 1'b0));
        add_fixed_row(make_access(K_PIXEL_READ, 13'h1FFF, 8'hFF, 1'b1, 8'd255, 8'd255, 1'b1),
                      make_result(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 9'h000, 9'h000, 3'd0, 1'b0));
        add_fixed_row(make_access(K_PIXEL_READ, 13'h0000, 8'h00, 1'b0, 8'd255, 8'd255, 1'b0),
                      make_result(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 9'h000, 9'h000, 3'd0, 1'b0));
        add_fixed_row(make_access(K_SCROLL_X, 13'h0000, 8'hFF, 1'b0, 8'd0, 8'd0, 1'b0),
                      make_result(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 9'h0FF, 9'h000, 3'd0, 1'b0));
        add_fixed_row(make_access(K_SCROLL_Y, 13'h0000, 8'hFF, 1'b1, 8'd0, 8'd0, 1'b0),
                      make_result(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 9'h0FF, 9'h1FF, 3'd0, 1'b0));
        // Palette index is taken from the low address byte only.
        add_fixed_row(make_access(K_PALETTE, 13'h1FFF, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0),
                      make_result(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 9'h0FF, 9'h1FF, 3'd0, 1'b0));
        add_fixed_row(make_access(K_PALETTE, 13'h0000, 8'hFF, 1'b0, 8'd0, 8'd0, 1'b0),
                      make_result(8'h00, 8'h00, 8'h00, 8'h21, 1'b1, 9'h0FF, 9'h1FF, 3'd0, 1'b0));
        add_fixed_row(make_access(K_CONTROL, 13'h0000, 8'hFF, 1'b0, 8'd0, 8'd0, 1'b0),
                      make_result(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 9'h0FF, 9'h1FF, 3'd0, 1'b0));
        // Control bit 0 supplies the ninth scroll x bit, bit 7 the low blue bit.
        add_row(make_access(K_SCROLL_X, 13'h0000, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0));
        add_row(make_access(K_PALETTE, 13'h0100, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0));
        // Control bits 3:1 all set give an empty plane mask, which writes all planes.
        add_row(make_access(K_BITMAP, 13'h1FFF, 8'hA5, 1'b0, 8'd0, 8'd0, 1'b0));
        add_row(make_access(K_PIXEL_READ, 13'h0000, 8'h00, 1'b0, 8'd248, 8'd255, 1'b0));
        add_row(make_access(K_PIXEL_READ, 13'h0000, 8'h00, 1'b0, 8'd0, 8'd0, 1'b1));
        add_row(make_access(K_CONTROL, 13'h0000, 8'h0C, 1'b0, 8'd0, 8'd0, 1'b0));
        add_row(make_access(K_BITMAP, 13'h1FFF, 8'h0F, 1'b0, 8'd0, 8'd0, 1'b0));
        add_row(make_access(K_PIXEL_READ, 13'h0000, 8'h00, 1'b0, 8'd252, 8'd255, 1'b0));
        add_row(make_access(K_CONTROL, 13'h0000, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0));
        add_row(make_access(K_BITMAP, 13'h0000, 8'hFF, 1'b0, 8'd0, 8'd0, 1'b0));
        add_row(make_access(K_PIXEL_READ, 13'h0000, 8'h00, 1'b0, 8'd7, 8'd0, 1'b0));
        add_row(make_access(K_BITMAP, 13'h0100, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0));
        add_row(make_access(K_BITMAP, 13'h1E00, 8'h81, 1'b0, 8'd0, 8'd0, 1'b0));
        add_row(make_access(K_PIXEL_READ, 13'h0000, 8'h00, 1'b0, 8'd8, 8'd255, 1'b1));
        // Unused kinds change nothing and only report the scroll values.
        add_row(make_access(K_UNUSED_LO, 13'h1FFF, 8'hFF, 1'b1, 8'd255, 8'd255, 1'b1));
        add_row(make_access(K_UNUSED_HI, 13'h0000, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0));
        add_row(make_access(K_SCROLL_Y, 13'h0000, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0));
    endtask

    task automatic refresh_hot_words();
        hot_words[0] = 13'h0000;
        hot_words[1] = 13'h1FFF;
        for (int i = 2; i < 16; i++) begin
            hot_words[i] = 13'($urandom_range(8191));
        end
    endtask

    // Bitmap writes and pixel reads mostly land on a small set of words so that
    // reads see the effect of earlier plane-masked writes.
    function automatic t_in_item random_access();
        t_in_item    acc;
        int unsigned pick;
        logic [12:0] word_addr;
        logic [7:0]  col;
        acc.address       = 13'($urandom_range(8191));
        acc.data          = 8'($urandom_range(255));
        acc.scroll_y_high = 1'($urandom_range(1));
        acc.pixel_x       = 8'($urandom_range(255));
        acc.pixel_y       = 8'($urandom_range(255));
        acc.flip          = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 8) begin
            acc.kind = K_CONTROL;
        end else if (pick < 12) begin
            acc.kind = K_SCROLL_X;
        end else if (pick < 16) begin
            acc.kind = K_SCROLL_Y;
        end else if (pick < 24) begin
            acc.kind = K_PALETTE;
        end else if (pick < 52) begin
            acc.kind = K_BITMAP;
            if ($urandom_range(9) < 8) begin
                acc.address = hot_words[4'($urandom_range(15))];
            end
        end else if (pick < 96) begin
            acc.kind = K_PIXEL_READ;
            if ($urandom_range(9) < 8) begin
                word_addr   = hot_words[4'($urandom_range(15))];
                col         = {word_addr[12:8], 3'($urandom_range(7))};
                acc.pixel_x = acc.flip ? ~col : col;
                acc.pixel_y = acc.flip ? ~word_addr[7:0] : word_addr[7:0];
            end
        end else begin
            acc.kind = $urandom_range(1) ? K_UNUSED_HI : K_UNUSED_LO;
        end
        return acc;
    endfunction

    task automatic send_access(input t_in_item acc, input bit fixed, input t_out_item fixed_res);
        t_out_item predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.item  <= acc;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        predicted = predict_access(acc);
        expected_results.push_back(fixed ? fixed_res : predicted);
    endtask

    task automatic wait_results_drained();
        do begin
            @(posedge i_clk);
        end while (expected_results.size() != 0);
    endtask

    function automatic void check_field(input string name, input logic [8:0] want,
                                        input logic [8:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $error("result transaction with no expectation pending");
            error_count++;
        end else begin
            want = expected_results.pop_front();
            check_field("color_index", 9'(want.color_index), 9'(got.color_index));
            check_field("red", 9'(want.red), 9'(got.red));
            check_field("green", 9'(want.green), 9'(got.green));
            check_field("blue", 9'(want.blue), 9'(got.blue));
            check_field("color_valid", 9'(want.color_valid), 9'(got.color_valid));
            check_field("scroll_x", want.scroll_x, got.scroll_x);
            check_field("scroll_y", want.scroll_y, got.scroll_y);
            check_field("pixel", 9'(want.pixel), 9'(got.pixel));
            check_field("pixel_opaque", 9'(want.pixel_opaque), 9'(got.pixel_opaque));
        end
    endtask

    // Result side: checks each transaction and drives ready, with an optional long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                check_result(out_if.item);
            end
            if (hold_request != hold_taken) begin
                hold_left  = LONG_HOLD;
                hold_taken = hold_request;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int idle_plan [NUM_PHASES];
        int stall_plan [NUM_PHASES];
        idle_plan      = '{0, 68, 0, 8};
        stall_plan     = '{0, 0, 68, 8};
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.item     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ctrl_reg       = '0;
        hscroll        = '0;
        vscroll        = '0;
        foreach (fb_words[i]) begin
            fb_words[i] = '0;
        end
        build_directed_rows();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_access(directed_rows[i].access, directed_rows[i].fixed,
                        directed_rows[i].fixed_result);
        end
        in_if.valid <= 1'b0;
        wait_results_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            refresh_hot_words();
            // With the sender never idle, a long result stall backs up into the input.
            if (p == 0) begin
                hold_request++;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_access(random_access(), 1'b0, '0);
            end
            in_if.valid <= 1'b0;
            wait_results_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- plane_bitmap_video_registers.f -----
hdl/pbvr_pkg.sv
hdl/pbvr_if.sv
hdl/pbvr_ram.sv
hdl/plane_bitmap_video_registers.sv
dv/tb_plane_bitmap_video_registers.sv
